// File: src/lre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lre_pkg;

    // Field widths fixed by the stream format.
    localparam int LEVEL_W    = 24;
    localparam int TIME_W     = 16;
    localparam int RATE_W     = 18;
    localparam int REQ_W      = 2;
    localparam int COUNT_W    = 24;
    localparam int PROD_W     = RATE_W + TIME_W;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 32;
    localparam int STEP_CNT_W = 7;

    // Sample rate after reset.
    localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(48000);

    // Division of rate * time by 1000: the product is first shifted right by
    // three (1000 = 8 * 125), then multiplied by ceil(2^38 / 125) and shifted
    // right by 38. This is exact for any shifted product below 2^31.
    localparam int                 MS_SHIFT     = 3;
    localparam int                 RECIP_W      = 32;
    localparam int                 RECIP_SHIFT  = 38;
    localparam logic [RECIP_W-1:0] RECIP_125    = 32'd2199023256;
    localparam int                 RECIP_PROD_W = PROD_W - MS_SHIFT + RECIP_W;

    // Request codes carried in the slave-side tuser.
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK = 2'd0,
        REQ_SET  = 2'd1,
        REQ_RAMP = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // Start command for the divider.
    typedef struct packed {
        logic                  start;
        logic [STEP_CNT_W-1:0] steps;
    } div_ctl_t;

endpackage

`default_nettype wire

// File: src/lre_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is loaded
// aligned to the top of the shift register; after ctl.steps steps the low
// ctl.steps bits hold the quotient and done pulses for one cycle.
module lre_div #(
    parameter int DIV_W = 48
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire lre_pkg::div_ctl_t          ctl,
    input  wire logic [DIV_W-1:0]           dividend,
    input  wire logic [lre_pkg::COUNT_W-1:0] divisor,
    output logic                            done,
    output logic [DIV_W-1:0]                quotient
);
    import lre_pkg::*;

    logic [DIV_W-1:0]      dq_reg;
    logic [COUNT_W-1:0]    rem_reg;
    logic [COUNT_W-1:0]    dvs_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [COUNT_W:0]      trial;
    logic [COUNT_W:0]      diff;
    logic                  fits;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        trial = {rem_reg, dq_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = ~diff[COUNT_W];
    end

    // Control: step counter, busy and done flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and dividend/quotient shift register.
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

`default_nettype wire

// File: src/linear_ramp_envelope.sv
// Linear ramp envelope generator.
//
// Items arrive on the s_axis channel: tuser carries the request (tick one
// sample, set the level, or start a ramp), tdata carries the target level and
// the ramp time in milliseconds. Every accepted beat yields exactly one beat
// on m_axis with the level after the request and a flag that is set once no
// ramp samples remain. The user writes the sample rate through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block does not enforce it.
//
// Ticks, level loads and unused codes pass through the decode and emit states
// before their result beat is presented, and no new item is taken until then.
// A ramp request forms rate * time in the decode state, turns it into a
// sample count by a reciprocal multiplication in the scale state, then
// divides the level span by that count in the restoring divider
// (VALUE_BITS + EXTRA_FRAC_BITS steps) before its beat is presented; a ramp of
// no samples skips the divider. One item is in flight at a time;
// s_axis_tready is high only while the sequencer is idle. When the receiver
// stalls, the beat stays in the output register; the next item may be
// accepted and worked on, but waits before presenting its beat. Reset clears
// the level, step and remaining sample count and sets the rate to 48000 Hz.
`timescale 1ns / 1ps
`default_nettype none

module linear_ramp_envelope #(
    parameter int VALUE_BITS      = 24,
    parameter int EXTRA_FRAC_BITS = 24
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [lre_pkg::RATE_W-1:0]   cfg_wr_data,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // [23:0] target_value, [39:24] ramp_time_ms
    input  wire logic [lre_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [1:0] req_type
    input  wire logic [lre_pkg::REQ_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [23:0] level_out, [24] finished, [31:25] zero
    output logic [lre_pkg::M_DATA_W-1:0]      m_axis_tdata
);
    import lre_pkg::*;

    localparam int ACC_BITS = VALUE_BITS + EXTRA_FRAC_BITS;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_DECODE    = 6'b000010,
        ST_SCALE     = 6'b000100,
        ST_COUNT     = 6'b001000,
        ST_WAIT_STEP = 6'b010000,
        ST_EMIT      = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [RATE_W-1:0]           rate_reg;
    req_t                        req_reg, req_next;
    logic signed [LEVEL_W-1:0]   tgt_reg, tgt_next;
    logic [TIME_W-1:0]           time_reg, time_next;
    logic [ACC_BITS-1:0]         level_reg, level_next;
    logic [ACC_BITS-1:0]         step_reg, step_next;
    logic [COUNT_W-1:0]          left_reg, left_next;
    logic [PROD_W-1:0]           prod_reg, prod_next;
    logic [COUNT_W-1:0]          count_reg, count_next;
    logic                        up_reg, up_next;
    logic                        m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]         m_data_reg, m_data_next;

    logic                        s_accept;
    logic [ACC_BITS-1:0]         tgt_acc;
    logic [PROD_W-1:0]           product;
    logic [RECIP_PROD_W-1:0]     recip_prod;
    logic [COUNT_W-1:0]          count_sat;
    logic                        go_up;
    logic [ACC_BITS-1:0]         span;
    logic signed [VALUE_BITS-1:0] level_top;
    logic [LEVEL_W-1:0]          level_out;

    div_ctl_t                    div_ctl;
    logic [ACC_BITS-1:0]         div_dividend;
    logic [COUNT_W-1:0]          div_divisor;
    logic                        div_done;
    logic [ACC_BITS-1:0]         div_quot;

    lre_div #(
        .DIV_W (ACC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Shared arithmetic: target in accumulator format, rate * time, the
    // sample count by reciprocal multiplication, and the direction and span
    // of the ramp.
    always_comb begin
        tgt_acc    = ACC_BITS'(tgt_reg) << EXTRA_FRAC_BITS;
        product    = PROD_W'(rate_reg) * PROD_W'(time_reg);
        recip_prod = RECIP_PROD_W'(prod_reg[PROD_W-1:MS_SHIFT])
                   * RECIP_PROD_W'(RECIP_125);
        count_sat  = (|recip_prod[RECIP_PROD_W-1:RECIP_SHIFT+COUNT_W])
                   ? {COUNT_W{1'b1}} : recip_prod[RECIP_SHIFT +: COUNT_W];
        go_up      = $signed(tgt_acc) >= $signed(level_reg);
        span       = go_up ? (tgt_acc - level_reg) : (level_reg - tgt_acc);
        level_top  = level_reg[ACC_BITS-1 -: VALUE_BITS];
        level_out  = LEVEL_W'(level_top);
    end

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        tgt_next     = tgt_reg;
        time_next    = time_reg;
        level_next   = level_reg;
        step_next    = step_reg;
        left_next    = left_reg;
        prod_next    = prod_reg;
        count_next   = count_reg;
        up_next      = up_reg;
        m_valid_next = m_valid_reg & ~m_axis_tready;
        m_data_next  = m_data_reg;
        div_ctl      = '0;
        div_dividend = '0;
        div_divisor  = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_next   = req_t'(s_axis_tuser);
                    tgt_next   = s_axis_tdata[LEVEL_W-1:0];
                    time_next  = s_axis_tdata[LEVEL_W +: TIME_W];
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_EMIT;
                unique case (req_reg)
                    REQ_TICK: begin
                        if (left_reg != '0) begin
                            left_next  = left_reg - COUNT_W'(1);
                            level_next = level_reg + step_reg;
                        end
                    end
                    REQ_SET: begin
                        level_next = tgt_acc;
                        step_next  = '0;
                        left_next  = '0;
                    end
                    REQ_RAMP: begin
                        prod_next  = product;
                        state_next = ST_SCALE;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCALE: begin
                // Sample count = rate * time / 1000.
                count_next = count_sat;
                state_next = ST_COUNT;
            end
            ST_COUNT: begin
                if (count_reg == '0) begin
                    // A ramp of no samples lands on the target at once.
                    level_next = tgt_acc;
                    step_next  = '0;
                    left_next  = '0;
                    state_next = ST_EMIT;
                end else begin
                    up_next       = go_up;
                    div_ctl.start = 1'b1;
                    div_ctl.steps = STEP_CNT_W'(ACC_BITS);
                    div_dividend  = span;
                    div_divisor   = count_reg;
                    state_next    = ST_WAIT_STEP;
                end
            end
            ST_WAIT_STEP: begin
                if (div_done) begin
                    step_next  = up_reg ? div_quot : (ACC_BITS'(0) - div_quot);
                    left_next  = count_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Present the beat once the output register is free.
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_DATA_W'({(left_reg == '0), level_out});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and envelope state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rate_reg    <= RATE_RESET;
            level_reg   <= '0;
            step_reg    <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            step_reg    <= step_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                rate_reg <= cfg_wr_data;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        tgt_reg    <= tgt_next;
        time_reg   <= time_next;
        prod_reg   <= prod_next;
        count_reg  <= count_next;
        up_reg     <= up_next;
        m_data_reg <= m_data_next;
    end

    // The divider only finishes while the sequencer waits for it.
    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_WAIT_STEP))
        else $error("divider finished outside a wait state");

    // An accepted beat closes the input until the item is done.
    a_accept_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (!s_axis_tready && state_reg == ST_DECODE))
        else $error("input still open after a beat was accepted");

    // A ramp that reaches the step division always leaves samples to run.
    a_ramp_has_samples: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT_STEP && div_done) |=> (left_reg != '0))
        else $error("ramp started with no samples left");

endmodule

`default_nettype wire
